// ===== rtl/crcfr_pkg.sv =====
// Package with the status codes, limits and CRC-16 update functions of the frame receiver.
package crcfr_pkg;

   typedef enum logic [2:0] {
      ST_NONE    = 3'd0,
      ST_GOOD    = 3'd1,
      ST_BADCRC  = 3'd2,
      ST_BADLEN  = 3'd3,
      ST_TIMEOUT = 3'd4
   } status_type;

   localparam logic [7:0]  MIN_LEN         = 8'd7;
   localparam logic [10:0] IDLE_MAX        = 11'd2047;
   localparam logic [9:0]  TIMEOUT_DEFAULT = 10'd50;
   localparam logic [7:0]  LEN_HDR_IDX     = 8'd4;
   localparam logic [7:0]  CODE_LO_IDX     = 8'd2;
   localparam logic [7:0]  CODE_HI_IDX     = 8'd3;

   // One nibble of CRC-16 with polynomial 0x1021: the table entry is the
   // carry-less product of the index nibble and the polynomial.
   function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
      logic [3:0] idx;
      idx = crc[15:12] ^ nib;
      return {idx, 12'h000} ^ {7'd0, idx, 5'd0} ^ {12'd0, idx} ^ {crc[11:0], 4'h0};
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] mid;
      mid = crc_nibble(crc, b[7:4]);
      return crc_nibble(mid, b[3:0]);
   endfunction

endpackage

// ===== rtl/crc16_frame_receiver_unit.sv =====
// Length-framed byte receiver with CRC-16 check, length check and idle timeout.
// A result is registered and valid in the cycle after the request that causes it is accepted.
// Throughput: one request per cycle unless stalled; a byte's two-nibble CRC update sits in it.
// A request is taken while a result waits, as long as that result is taken in the same cycle.
// Reset is synchronous and active high: no frame in progress, no result, timeout 50 ticks.
module crc16_frame_receiver_unit import crcfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_transfer_code,
   output logic [7:0]  rsp_frame_length,
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data
);

   logic [9:0]  rx_timeout_ff;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [15:0] crc_acc_ff, crc_acc_in;
   logic [7:0]  length_seen_ff, length_seen_in;
   logic [15:0] code_seen_ff, code_seen_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [10:0] idle_ticks_ff, idle_ticks_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_code_ff, rsp_code_in;
   logic [7:0]  rsp_length_ff, rsp_length_in;

   logic        accept;
   status_type  status;
   logic [15:0] crc_base;
   logic [15:0] crc_next;
   logic [15:0] code_base;
   logic [7:0]  len_minus2;
   logic [15:0] rx_crc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      byte_count_in  = byte_count_ff;
      crc_acc_in     = crc_acc_ff;
      length_seen_in = length_seen_ff;
      code_seen_in   = code_seen_ff;
      crc_low_in     = crc_low_ff;
      idle_ticks_in  = idle_ticks_ff;
      status         = ST_NONE;

      // A new frame starts from a cleared CRC and cleared header fields.
      crc_base   = (byte_count_ff == 8'd0) ? 16'd0 : crc_acc_ff;
      code_base  = (byte_count_ff == 8'd0) ? 16'd0 : code_seen_ff;
      crc_next   = crc_byte(crc_base, req_rx_byte);
      len_minus2 = length_seen_ff - 8'd2;
      rx_crc     = {req_rx_byte, crc_low_ff};

      if (accept) begin
         if (req_type) begin
            if (byte_count_ff != 8'd0) begin
               if (idle_ticks_ff != IDLE_MAX) begin
                  idle_ticks_in = idle_ticks_ff + 11'd1;
               end
               if (idle_ticks_in > {1'b0, rx_timeout_ff}) begin
                  status        = ST_TIMEOUT;
                  byte_count_in = 8'd0;
                  idle_ticks_in = 11'd0;
               end
            end
         end else begin
            idle_ticks_in = 11'd0;
            if (byte_count_ff == 8'd0) begin
               length_seen_in = 8'd0;
               crc_low_in     = 8'd0;
            end
            code_seen_in = code_base;
            if (byte_count_ff <= LEN_HDR_IDX) begin
               crc_acc_in    = crc_next;
               byte_count_in = byte_count_ff + 8'd1;
               if (byte_count_ff == CODE_LO_IDX) begin
                  code_seen_in = {code_base[15:8], req_rx_byte};
               end else if (byte_count_ff == CODE_HI_IDX) begin
                  code_seen_in = {req_rx_byte, code_base[7:0]};
               end
               if (byte_count_ff == LEN_HDR_IDX) begin
                  length_seen_in = req_rx_byte;
                  if (req_rx_byte < MIN_LEN) begin
                     status        = ST_BADLEN;
                     byte_count_in = 8'd0;
                  end
               end
            end else begin
               // Past the header the length is at least seven, so the CRC
               // bytes sit at length-2 and length-1.
               priority if (byte_count_ff < len_minus2) begin
                  crc_acc_in    = crc_next;
                  byte_count_in = byte_count_ff + 8'd1;
               end else if (byte_count_ff == len_minus2) begin
                  crc_low_in    = req_rx_byte;
                  byte_count_in = byte_count_ff + 8'd1;
               end else begin
                  status        = (rx_crc == crc_acc_ff) ? ST_GOOD : ST_BADCRC;
                  byte_count_in = 8'd0;
               end
            end
         end
      end

      rsp_status_in = rsp_status_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_length_in = rsp_length_ff;
      if (accept && status != ST_NONE) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_code_in   = code_seen_in;
         rsp_length_in = length_seen_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_timeout_ff  <= TIMEOUT_DEFAULT;
         byte_count_ff  <= 8'd0;
         crc_acc_ff     <= 16'd0;
         length_seen_ff <= 8'd0;
         code_seen_ff   <= 16'd0;
         crc_low_ff     <= 8'd0;
         idle_ticks_ff  <= 11'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            rx_timeout_ff <= csr_wr_data;
         end
         byte_count_ff  <= byte_count_in;
         crc_acc_ff     <= crc_acc_in;
         length_seen_ff <= length_seen_in;
         code_seen_ff   <= code_seen_in;
         crc_low_ff     <= crc_low_in;
         idle_ticks_ff  <= idle_ticks_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_transfer_code = rsp_code_ff;
   assign rsp_frame_length  = rsp_length_ff;

   // Only reportable events reach the result channel.
   a_rsp_has_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_status_ff != ST_NONE)
      else $error("result presented with no status");

   // Idle ticks are only counted inside a frame.
   a_idle_only_in_frame: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff == 8'd0 |-> idle_ticks_ff == 11'd0)
      else $error("idle ticks counted with no frame in progress");

   // A frame past its header always carries a legal length.
   a_len_legal: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff > 8'd5 |-> length_seen_ff >= MIN_LEN)
      else $error("frame body with illegal length");

   // A tick outside a frame produces no result.
   a_quiet_tick: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type && byte_count_ff == 8'd0) |=> !rsp_valid_ff)
      else $error("result produced by a tick outside a frame");

endmodule

// ===== bench/tb_crc16_frame_receiver_unit.sv =====
// Testbench for the CRC-16 frame receiver: random and directed frames checked against a predictor.
`timescale 1ns / 1ps

module tb_crc16_frame_receiver_unit import crcfr_pkg::*; ();

   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned ITEM_TARGET   = 1050;
   localparam int unsigned PHASE_ITEMS   = 130;
   localparam int unsigned HOLD_CYCLES   = 400;

   typedef enum logic [1:0] {
      ENT_REQ,
      ENT_DRAIN,
      ENT_CFG
   } entry_kind_type;

   typedef struct {
      entry_kind_type kind;
      logic           is_tick;
      logic [9:0]     value;
      int unsigned    gap;
   } pending_entry_type;

   typedef struct {
      status_type  rep_status;
      logic [15:0] rep_code;
      logic [7:0]  rep_length;
   } frame_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_transfer_code;
   logic [7:0]  rsp_frame_length;
   logic        csr_wr_en = 1'b0;
   logic [9:0]  csr_wr_data = 10'd0;

   // Receiver state as the predictor sees it.
   logic [7:0]  rcv_count = 8'd0;
   logic [15:0] rcv_crc = 16'd0;
   logic [7:0]  rcv_len = 8'd0;
   logic [15:0] rcv_code = 16'd0;
   logic [7:0]  rcv_crc_lo = 8'd0;
   logic [10:0] rcv_idle = 11'd0;
   logic [9:0]  rcv_timeout = TIMEOUT_DEFAULT;

   frame_report_type  expected_reports[$];
   pending_entry_type pending_reqs[$];

   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   int unsigned error_count = 0;
   int unsigned reqs_accepted = 0;
   int unsigned timeout_writes = 0;
   int unsigned status_seen[5];
   int unsigned gap_count = 0;
   int unsigned settle_count = 0;
   int unsigned rsp_wait_left = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned rsp_total = 0;
   int unsigned items_queued = 0;
   int unsigned gen_timeout = TIMEOUT_DEFAULT;
   bit          gen_calm = 1'b0;

   crc16_frame_receiver_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_transfer_code (rsp_transfer_code),
      .rsp_frame_length  (rsp_frame_length),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #6 clock = ~clock;

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
   end

   // Bitwise CRC-16 with polynomial 0x1021, MSB first.
   function automatic logic [15:0] crc16_add_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
   endfunction

   task automatic predict_request(input logic is_tick, input logic [7:0] b);
      frame_report_type rep;
      logic [7:0]       idx;
      logic [15:0]      rx_crc;
      rep.rep_status = ST_NONE;
      rep.rep_code = 16'd0;
      rep.rep_length = 8'd0;
      if (is_tick) begin
         if (rcv_count != 8'd0) begin
            if (rcv_idle < IDLE_MAX) rcv_idle = rcv_idle + 11'd1;
            if (rcv_idle > {1'b0, rcv_timeout}) begin
               rep.rep_status = ST_TIMEOUT;
               rcv_count = 8'd0;
               rcv_idle = 11'd0;
            end
         end
      end else begin
         idx = rcv_count;
         rcv_idle = 11'd0;
         if (idx == 8'd0) begin
            rcv_crc = 16'd0;
            rcv_code = 16'd0;
            rcv_len = 8'd0;
            rcv_crc_lo = 8'd0;
         end
         if (idx <= LEN_HDR_IDX) begin
            rcv_crc = crc16_add_byte(rcv_crc, b);
            if (idx == CODE_LO_IDX) rcv_code[7:0] = b;
            else if (idx == CODE_HI_IDX) rcv_code[15:8] = b;
            if (idx == LEN_HDR_IDX) begin
               rcv_len = b;
               if (b < MIN_LEN) begin
                  rep.rep_status = ST_BADLEN;
                  rcv_count = 8'd0;
                  rcv_idle = 11'd0;
               end else begin
                  rcv_count = idx + 8'd1;
               end
            end else begin
               rcv_count = idx + 8'd1;
            end
         end else if (idx < rcv_len - 8'd2) begin
            rcv_crc = crc16_add_byte(rcv_crc, b);
            rcv_count = idx + 8'd1;
         end else if (idx == rcv_len - 8'd2) begin
            rcv_crc_lo = b;
            rcv_count = idx + 8'd1;
         end else begin
            rx_crc = {b, rcv_crc_lo};
            if (rx_crc == rcv_crc) rep.rep_status = ST_GOOD;
            else rep.rep_status = ST_BADCRC;
            rcv_count = 8'd0;
            rcv_idle = 11'd0;
         end
      end
      if (rep.rep_status != ST_NONE) begin
         rep.rep_code = rcv_code;
         rep.rep_length = rcv_len;
         expected_reports.push_back(rep);
      end
   endtask

   // Monitor: checks accepted reports, then predicts from the accepted request.
   always @(posedge clock) begin : watch
      frame_report_type exp_rep;
      if (reset) begin
         rcv_count = 8'd0;
         rcv_crc = 16'd0;
         rcv_len = 8'd0;
         rcv_code = 16'd0;
         rcv_crc_lo = 8'd0;
         rcv_idle = 11'd0;
         rcv_timeout = TIMEOUT_DEFAULT;
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected report, expected none, got status %0d code %h length %0d",
                        $time, rsp_status, rsp_transfer_code, rsp_frame_length);
               error_count++;
            end else begin
               exp_rep = expected_reports.pop_front();
               status_seen[exp_rep.rep_status]++;
               if (rsp_status !== exp_rep.rep_status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, exp_rep.rep_status, rsp_status);
                  error_count++;
               end
               if (rsp_transfer_code !== exp_rep.rep_code) begin
                  $display("%0t: transfer code mismatch, expected %h, got %h",
                           $time, exp_rep.rep_code, rsp_transfer_code);
                  error_count++;
               end
               if (rsp_frame_length !== exp_rep.rep_length) begin
                  $display("%0t: frame length mismatch, expected %0d, got %0d",
                           $time, exp_rep.rep_length, rsp_frame_length);
                  error_count++;
               end
            end
         end
         if (csr_wr_en) rcv_timeout = csr_wr_data;
         if (req_valid && req_ready) begin
            predict_request(req_type, req_rx_byte);
            reqs_accepted++;
         end
      end
   end

   // Driver: offers one request at a time; timeout writes wait for the block to go idle.
   always @(negedge clock) begin : sender
      logic              offer;
      logic              wr;
      pending_entry_type cur;
      offer = req_valid && !req_taken;
      wr = 1'b0;
      if (!reset && !offer && pending_reqs.size() != 0) begin
         if (pending_reqs[0].kind == ENT_REQ) begin
            if (gap_count < pending_reqs[0].gap) begin
               gap_count++;
            end else begin
               gap_count = 0;
               cur = pending_reqs.pop_front();
               offer = 1'b1;
               req_type <= cur.is_tick;
               req_rx_byte <= cur.value[7:0];
            end
         end else if (expected_reports.size() != 0 || rsp_valid) begin
            settle_count = 0;
         end else if (settle_count < SETTLE_CYCLES) begin
            settle_count++;
         end else begin
            settle_count = 0;
            cur = pending_reqs.pop_front();
            if (cur.kind == ENT_CFG) begin
               wr = 1'b1;
               csr_wr_data <= cur.value;
               timeout_writes++;
            end
         end
      end
      req_valid <= offer;
      csr_wr_en <= wr;
   end

   // Report side: random stalls per report, calm stretches, and long holds to back up the block.
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_total++;
            rsp_wait_left = ((rsp_total / 16) % 4 == 3) ? 0 : $urandom_range(0, 7);
            if (rsp_total == 15 || rsp_total == 70) rsp_hold_left = HOLD_CYCLES;
         end
         if (rsp_hold_left != 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_wait_left != 0) begin
            rsp_wait_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic add_req(input logic is_tick, input logic [7:0] b);
      pending_entry_type e;
      e.kind = ENT_REQ;
      e.is_tick = is_tick;
      e.value = {2'b00, b};
      e.gap = gen_calm ? 0 : $urandom_range(0, 7);
      pending_reqs.push_back(e);
      items_queued++;
   endtask

   task automatic add_ticks(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) add_req(1'b1, 8'($urandom));
   endtask

   task automatic add_control(input entry_kind_type kind, input logic [9:0] v);
      pending_entry_type e;
      e.kind = kind;
      e.is_tick = 1'b0;
      e.value = v;
      e.gap = 0;
      pending_reqs.push_back(e);
      if (kind == ENT_CFG) gen_timeout = v;
   endtask

   // Builds a frame; cut, when nonzero, sends only its first bytes.
   task automatic add_frame(input int flen, input logic [15:0] code, input bit corrupt,
                            input int cut);
      logic [7:0]  fb[$];
      logic [15:0] crc;
      int unsigned lim;
      int          n;
      fb.push_back(8'($urandom));
      fb.push_back(8'($urandom));
      fb.push_back(code[7:0]);
      fb.push_back(code[15:8]);
      fb.push_back(8'(flen));
      if (flen >= MIN_LEN) begin
         while (fb.size() < flen - 2) fb.push_back(8'($urandom));
         crc = 16'd0;
         foreach (fb[i]) crc = crc16_add_byte(crc, fb[i]);
         if (corrupt) crc ^= 16'(1 << $urandom_range(0, 15));
         fb.push_back(crc[7:0]);
         fb.push_back(crc[15:8]);
      end
      lim = (gen_timeout < 8) ? gen_timeout : 8;
      n = (cut != 0 && cut < fb.size()) ? cut : fb.size();
      for (int i = 0; i < n; i++) begin
         // Idle ticks inside the frame, sometimes exactly at the timeout.
         if (i != 0 && $urandom_range(0, 6) == 0) begin
            if ($urandom_range(0, 3) == 0 && gen_timeout <= 60) add_ticks(gen_timeout);
            else add_ticks($urandom_range(0, lim));
         end
         add_req(1'b0, fb[i]);
      end
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned phase_start;
      int unsigned pick;
      int          flen;

      // Directed part: extremes and each special case.
      add_req(1'b1, 8'hA5);
      add_frame(7, 16'hFFFF, 1'b0, 0);
      add_frame(0, 16'h0000, 1'b0, 0);
      add_frame(6, 16'h5AA5, 1'b0, 0);
      add_frame(8, 16'h00FF, 1'b1, 0);
      add_control(ENT_CFG, 10'd1);
      add_frame(9, 16'hFF00, 1'b0, 2);
      add_ticks(2);
      add_frame(255, 16'h8001, 1'b0, 4);
      add_ticks(1);
      add_ticks(1);

      phase = 0;
      while (items_queued < ITEM_TARGET) begin
         case (phase % 8)
            0: add_control(ENT_CFG, 10'd1);
            1: add_control(ENT_CFG, 10'd1000);
            2: add_control(ENT_CFG, 10'($urandom_range(2, 30)));
            3: add_control(ENT_CFG, TIMEOUT_DEFAULT);
            4: add_control(ENT_CFG, 10'($urandom_range(31, 1000)));
            5: add_control(ENT_CFG, 10'd3);
            6: add_control(ENT_CFG, 10'($urandom_range(1, 1000)));
            default: add_control(ENT_CFG, 10'($urandom_range(1, 20)));
         endcase
         gen_calm = (phase % 3 == 1);
         if (phase == 1) add_frame(255, 16'($urandom), 1'b0, 0);
         phase_start = items_queued;
         while (items_queued - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               flen = $urandom_range(0, 99);
               if (flen < 90) flen = $urandom_range(7, 16);
               else if (flen < 99) flen = $urandom_range(17, 64);
               else flen = $urandom_range(65, 200);
               add_frame(flen, 16'($urandom), $urandom_range(0, 4) == 0, 0);
            end else if (pick < 80) begin
               add_frame($urandom_range(0, 6), 16'($urandom), 1'b0, 0);
            end else if (pick < 90 && gen_timeout <= 60) begin
               // Broken frame: cut short, then left idle until it is dropped.
               flen = $urandom_range(7, 16);
               add_frame(flen, 16'($urandom), 1'b0, $urandom_range(1, flen - 1));
               add_ticks(gen_timeout + 1);
            end else begin
               add_ticks($urandom_range(1, 4));
            end
         end
         if (phase % 4 == 3) add_control(ENT_DRAIN, 10'd0);
         phase++;
      end

      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_reports.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      $display("Accepted %0d requests over %0d timeout settings.", reqs_accepted, timeout_writes);
      $display("Reports: %0d good, %0d CRC errors, %0d length errors, %0d timeout drops.",
               status_seen[ST_GOOD], status_seen[ST_BADCRC], status_seen[ST_BADLEN],
               status_seen[ST_TIMEOUT]);
      if (error_count == 0 && expected_reports.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(5_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule
